FILE: rtl/krle_pkg.sv
package krle_pkg;

	// List geometry.
	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int RCOUNT_W = 6;
	localparam int COUNT_W  = ($clog2(CAPACITY + 1) > RCOUNT_W) ?
		$clog2(CAPACITY + 1) : RCOUNT_W;

	// Operation codes.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_DUMP   = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// One stored record.
	typedef struct packed {
		logic signed [31:0] key;
		logic [31:0]        payload;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       rd_first;
		logic       step;
		logic       tail;
		logic       reply;
		logic [1:0] status;
		logic       rec_valid;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       emit_dump;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       count_zero;
		logic       count_full;
		logic       scan_last;
		logic       found;
		logic       out_free;
	} stat_t;

endpackage

FILE: rtl/krle_ctrl.sv
module krle_ctrl import krle_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_TAIL  = 3'd3;
	localparam logic [2:0] S_REPLY = 3'd4;
	localparam logic [2:0] S_DUMP  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// One item is worked on at a time.
	assign in_stall = (state_q != S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				unique case (stat.op) inside
					OP_APPEND, OP_INSERT: begin
						if (stat.count_full) begin
							state_d = S_REPLY;
						end else if (stat.op == OP_APPEND || stat.count_zero) begin
							state_d = S_TAIL;
						end else begin
							cmd.rd_first = 1'b1;
							state_d      = S_SCAN;
						end
					end
					OP_DELETE: begin
						if (stat.count_zero) begin
							state_d = S_REPLY;
						end else begin
							cmd.rd_first = 1'b1;
							state_d      = S_SCAN;
						end
					end
					default: begin
						if (stat.count_zero) begin
							state_d = S_REPLY;
						end else begin
							cmd.rd_first = 1'b1;
							state_d      = S_DUMP;
						end
					end
				endcase
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (stat.scan_last) begin
					state_d = (stat.op == OP_INSERT) ? S_TAIL : S_REPLY;
				end
			end
			S_TAIL: begin
				cmd.tail = 1'b1;
				state_d  = S_REPLY;
			end
			S_REPLY: begin
				if (stat.out_free) begin
					cmd.reply = 1'b1;
					state_d   = S_IDLE;
					unique case (stat.op) inside
						OP_APPEND, OP_INSERT: begin
							if (stat.count_full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.status  = ST_OK;
								cmd.cnt_inc = 1'b1;
							end
						end
						OP_DELETE: begin
							if (stat.count_zero) begin
								cmd.status = ST_EMPTY;
							end else if (stat.found) begin
								cmd.status    = ST_OK;
								cmd.rec_valid = 1'b1;
								cmd.cnt_dec   = 1'b1;
							end else begin
								cmd.status = ST_NOT_FOUND;
							end
						end
						default: begin
							cmd.status = ST_EMPTY;
						end
					endcase
				end
			end
			S_DUMP: begin
				if (stat.out_free) begin
					cmd.emit_dump = 1'b1;
					if (stat.scan_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/krle_dp.sv
module krle_dp import krle_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  key,
	input  logic [31:0]         payload,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic                record_valid,
	output logic signed [31:0]  out_key,
	output logic [31:0]         out_payload,
	output logic [RCOUNT_W-1:0] record_count,
	output logic                last
);

	rec_t               mem [CAPACITY];
	rec_t               rd_q;
	rec_t               carry_q;
	rec_t               del_q;
	logic [1:0]         op_q;
	logic signed [31:0] key_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] idx_q;
	logic [COUNT_W-1:0] idx_inc;
	logic               found_q;
	logic               hit;
	logic               match;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	rec_t               wr_data;
	logic               out_free;

	// Compare of the entry currently read against the item key.
	assign hit   = found_q || (rd_q.key >= key_q);
	assign match = (rd_q.key == key_q);

	assign idx_inc = idx_q + COUNT_W'(1);
	assign out_free = !out_valid || !out_stall;

	// Status toward the controller.
	assign stat.op         = op_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = (count_q >= COUNT_W'(CAPACITY));
	assign stat.scan_last  = (idx_inc == count_q);
	assign stat.found      = found_q;
	assign stat.out_free   = out_free;

	// Read port: first entry, or the one after the entry now being handled.
	assign rd_en   = cmd.rd_first || cmd.step || cmd.emit_dump;
	assign rd_addr = cmd.rd_first ? '0 : idx_inc[ADDR_W-1:0];

	// Write port: insert ripples the carried record forward, delete
	// moves later entries down by one, tail places the carried record.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[ADDR_W-1:0];
		wr_data = carry_q;
		if (cmd.tail) begin
			wr_en   = 1'b1;
			wr_addr = count_q[ADDR_W-1:0];
		end else if (cmd.step && op_q == OP_INSERT && hit) begin
			wr_en = 1'b1;
		end else if (cmd.step && op_q == OP_DELETE && found_q) begin
			wr_en   = 1'b1;
			wr_addr = ADDR_W'(idx_q - COUNT_W'(1));
			wr_data = rd_q;
		end
	end

	// Record memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Item registers, carried record and deleted record.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q          <= operation;
			key_q         <= key;
			carry_q.key     <= key;
			carry_q.payload <= payload;
		end else if (cmd.step && op_q == OP_INSERT && hit) begin
			carry_q <= rd_q;
		end
		if (cmd.step && op_q == OP_DELETE && !found_q && match) begin
			del_q <= rd_q;
		end
	end

	// Next record count.
	always_comb begin
		count_d = count_q;
		if (cmd.reply && cmd.cnt_inc) begin
			count_d = count_q + COUNT_W'(1);
		end else if (cmd.reply && cmd.cnt_dec) begin
			count_d = count_q - COUNT_W'(1);
		end
	end

	// Control state: count, scan index, found flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.rd_first) begin
				idx_q <= '0;
			end else if (cmd.step || cmd.emit_dump) begin
				idx_q <= idx_inc;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.step) begin
				if (op_q == OP_INSERT) begin
					found_q <= hit;
				end else if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.reply || cmd.emit_dump) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			status       <= cmd.status;
			record_valid <= cmd.rec_valid;
			out_key      <= cmd.rec_valid ? del_q.key : '0;
			out_payload  <= cmd.rec_valid ? del_q.payload : '0;
			record_count <= count_d[RCOUNT_W-1:0];
			last         <= 1'b1;
		end else if (cmd.emit_dump) begin
			status       <= ST_OK;
			record_valid <= 1'b1;
			out_key      <= rd_q.key;
			out_payload  <= rd_q.payload;
			record_count <= count_q[RCOUNT_W-1:0];
			last         <= stat.scan_last;
		end
	end

endmodule

FILE: rtl/keyed_record_list_engine_top.sv
// Ordered list of up to 32 key and payload records held in a single-port
// read, single-port write memory. The block takes one item at a time. An
// append, a refused append or insert, and an operation on an empty list do
// not walk the memory; insert and delete walk it one entry per cycle to find
// the place and to shift the records behind it. A dump gives one record per
// cycle, slowed only by stall on the result side. The result register lets a
// new item be taken while the last result still waits. Memory contents come
// up undefined after reset; only entries below the record count are ever
// used.
module keyed_record_list_engine_top import krle_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  key,
	input  logic [31:0]         payload,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic                record_valid,
	output logic signed [31:0]  out_key,
	output logic [31:0]         out_payload,
	output logic [RCOUNT_W-1:0] record_count,
	output logic                last
);

	cmd_t  cmd;
	stat_t stat;

	// Operation sequencer.
	krle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Record store, count and result register.
	krle_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.key          (key),
		.payload      (payload),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.record_valid (record_valid),
		.out_key      (out_key),
		.out_payload  (out_payload),
		.record_count (record_count),
		.last         (last)
	);

endmodule

FILE: rtl/krle_checker.sv
module krle_checker import krle_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [1:0]          status,
	input logic                record_valid,
	input logic signed [31:0]  out_key,
	input logic [31:0]         out_payload,
	input logic [RCOUNT_W-1:0] record_count,
	input logic                last
);

	// A stalled result holds its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_key)
			&& $stable(out_payload) && $stable(last))
		else $error("stalled result changed");

	// An accepted item raises the stall in the following cycle, blocking the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item in progress");

	// A result without a record carries zero key and payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_valid |-> out_key == '0 && out_payload == '0)
		else $error("record fields not zero without a record");

	// Error statuses end the item and carry no record.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && !record_valid)
		else $error("error status without last or with record");

	// A valid result's record count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> record_count <= RCOUNT_W'(CAPACITY))
		else $error("record count above capacity");

endmodule

bind keyed_record_list_engine_top krle_checker u_krle_checker (.*);

FILE: verif/keyed_record_list_engine_top_tb.sv
`timescale 1ns / 1ps

module keyed_record_list_engine_top_tb;
	import krle_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_OFF_CYCLES = 400;

	// One result item as the block should present it.
	typedef struct {
		logic [1:0]          status;
		logic                record_valid;
		logic signed [31:0]  rec_key;
		logic [31:0]         rec_payload;
		logic [RCOUNT_W-1:0] record_count;
		logic                last;
	} list_result_t;

	// Mirror of the record list plus the queue of results still owed by the block.
	class record_list_tracker;
		logic signed [31:0] keys [CAPACITY];
		logic [31:0]        payloads [CAPACITY];
		int                 count;
		list_result_t       owed_results[$];
		int                 errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void owe(logic [1:0] st, logic vld, logic signed [31:0] k,
				logic [31:0] p, logic lst);
			list_result_t r;
			r.status = st;
			r.record_valid = vld;
			r.rec_key = vld ? k : 32'sd0;
			r.rec_payload = vld ? p : 32'd0;
			r.record_count = count[RCOUNT_W-1:0];
			r.last = lst;
			owed_results.push_back(r);
		endfunction

		// Apply one accepted item to the mirror and queue the results it causes.
		function void note_item(logic [1:0] op, logic signed [31:0] k, logic [31:0] p);
			int pos;
			case (op)
				OP_APPEND, OP_INSERT: begin
					if (count >= CAPACITY) begin
						owe(ST_FULL, 1'b0, 0, 0, 1'b1);
					end else begin
						pos = count;
						if (op == OP_INSERT) begin
							for (int i = 0; i < count; i++) begin
								if (keys[i] >= k) begin
									pos = i;
									break;
								end
							end
							for (int i = count; i > pos; i--) begin
								keys[i] = keys[i-1];
								payloads[i] = payloads[i-1];
							end
						end
						keys[pos] = k;
						payloads[pos] = p;
						count++;
						owe(ST_OK, 1'b0, 0, 0, 1'b1);
					end
				end
				OP_DELETE: begin
					if (count == 0) begin
						owe(ST_EMPTY, 1'b0, 0, 0, 1'b1);
					end else begin
						pos = count;
						for (int i = 0; i < count; i++) begin
							if (keys[i] == k) begin
								pos = i;
								break;
							end
						end
						if (pos >= count) begin
							owe(ST_NOT_FOUND, 1'b0, 0, 0, 1'b1);
						end else begin
							k = keys[pos];
							p = payloads[pos];
							for (int i = pos; i + 1 < count; i++) begin
								keys[i] = keys[i+1];
								payloads[i] = payloads[i+1];
							end
							count--;
							owe(ST_OK, 1'b1, k, p, 1'b1);
						end
					end
				end
				default: begin
					if (count == 0) begin
						owe(ST_EMPTY, 1'b0, 0, 0, 1'b1);
					end else begin
						for (int i = 0; i < count; i++)
							owe(ST_OK, 1'b1, keys[i], payloads[i], i + 1 == count);
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (exp_val !== act_val) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val,
					act_val);
			end
		endfunction

		// Compare one accepted result against the oldest owed one.
		function void check_result(list_result_t got);
			list_result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got status %h key %h",
					$time, got.status, got.rec_key);
				return;
			end
			want = owed_results.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("record_valid", 32'(want.record_valid), 32'(got.record_valid));
			compare_field("out_key", want.rec_key, got.rec_key);
			compare_field("out_payload", want.rec_payload, got.rec_payload);
			compare_field("record_count", 32'(want.record_count), 32'(got.record_count));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction

		function logic signed [31:0] pick_held_key();
			if (count == 0)
				return $urandom;
			return keys[$urandom_range(count - 1)];
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          operation;
	logic signed [31:0]  key;
	logic [31:0]         payload;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic                record_valid;
	logic signed [31:0]  out_key;
	logic [31:0]         out_payload;
	logic [RCOUNT_W-1:0] record_count;
	logic                last;

	record_list_tracker tracker;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;

	keyed_record_list_engine_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.key          (key),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.record_valid (record_valid),
		.out_key      (out_key),
		.out_payload  (out_payload),
		.record_count (record_count),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("keyed_record_list_engine_top verification failed");
			$finish;
		end
	end

	// Result side stall: random, or a long hold-off counted down here.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// Check every accepted result item.
	always @(posedge clk) begin
		list_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.record_valid = record_valid;
			got.rec_key = out_key;
			got.rec_payload = out_payload;
			got.record_count = record_count;
			got.last = last;
			tracker.check_result(got);
		end
	end

	// Offer one item, with random idle cycles ahead of it, and wait for acceptance.
	task automatic send_item(input logic [1:0] op, input logic signed [31:0] k,
			input logic [31:0] p);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		payload <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_item(op, k, p);
		@(negedge clk);
	endtask

	// Random item; keys favor those already held so deletes hit and inserts tie.
	task automatic random_item(input int add_pct, input int del_pct);
		int pick;
		logic [1:0] op;
		logic signed [31:0] k;
		pick = $urandom_range(99);
		if (pick < add_pct)
			op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
		else if (pick < add_pct + del_pct)
			op = OP_DELETE;
		else
			op = OP_DUMP;
		case ($urandom_range(9))
			0, 1, 2, 3: k = tracker.pick_held_key();
			4: k = 32'sh8000_0000;
			5: k = 32'sh7fff_ffff;
			6: k = $signed(32'($urandom_range(4))) - 32'sd2;
			default: k = $urandom;
		endcase
		send_item(op, k, $urandom);
	endtask

	// Stop offering items and wait until every owed result has come.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.owed_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int n;
		bit hit_full;
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_APPEND;
		key = 32'sd0;
		payload = 32'd0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty list cases, key extremes, ties, unsorted tail, misses.
		send_item(OP_DUMP, 32'sd0, 32'd0);
		send_item(OP_DELETE, 32'sd0, 32'd0);
		send_item(OP_APPEND, 32'sh8000_0000, 32'h0000_0000);
		send_item(OP_APPEND, 32'sh7fff_ffff, 32'hffff_ffff);
		send_item(OP_INSERT, 32'sd0, 32'ha5a5_a5a5);
		send_item(OP_INSERT, 32'sh8000_0000, 32'h0000_0001);
		send_item(OP_INSERT, 32'sh7fff_ffff, 32'h0000_0002);
		send_item(OP_APPEND, -32'sd1, 32'h0000_0003);
		send_item(OP_DUMP, 32'sd0, 32'd0);
		send_item(OP_DELETE, 32'sd12345, 32'd0);
		send_item(OP_DELETE, 32'sh7fff_ffff, 32'd0);
		send_item(OP_DELETE, 32'sh8000_0000, 32'd0);
		send_item(OP_DUMP, 32'sd0, 32'd0);
		send_item(OP_INSERT, 32'sd7, 32'h5a5a_5a5a);
		send_item(OP_DELETE, -32'sd1, 32'hffff_ffff);
		send_item(OP_DUMP, 32'sh7fff_ffff, 32'hffff_ffff);

		// Random phases: mostly adds, aiming to fill the list, then mostly deletes to drain it.
		for (int phase = 0; phase < 4; phase++) begin
			wait_all_results();
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
				default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
			endcase
			if (phase == 0)
				hold_left = HOLD_OFF_CYCLES;
			n = 0;
			hit_full = 1'b0;
			while (n < 40 || (!hit_full && n < 120)) begin
				random_item(85, 10);
				if (tracker.count == CAPACITY)
					hit_full = 1'b1;
				n++;
			end
			repeat (25) random_item(10, 75);
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
			$display("keyed_record_list_engine_top verification clean");
		end else begin
			$display("keyed_record_list_engine_top verification failed");
		end
		$finish;
	end

endmodule
